/* hw/rtl/line_segment_rect_clip_core_assert.svh */
// Assertion macros for the segment clipping core.
// Needs a clock, an active-low reset and property expressions from the includer.
`ifndef LINE_SEGMENT_RECT_CLIP_CORE_ASSERT_SVH
`define LINE_SEGMENT_RECT_CLIP_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define LSRC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset
`define LSRC_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lsrc_pkg.sv */
// Shared types, widths and outcode helper for the segment clipping core.
// No dependencies.
package lsrc_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int MAX_CLIP_STEPS = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int MAG_W          = COORD_WIDTH;
	localparam int DIFF_W         = COORD_WIDTH + 1;
	localparam int PROD_W         = 2 * MAG_W;
	localparam int SUM_W          = PROD_W + 2;

	localparam logic [3:0] OC_TOP    = 4'h1;
	localparam logic [3:0] OC_BOTTOM = 4'h2;
	localparam logic [3:0] OC_RIGHT  = 4'h4;
	localparam logic [3:0] OC_LEFT   = 4'h8;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_MIN = 2'd0,
		CFG_ROW_MAX = 2'd1,
		CFG_COL_MIN = 2'd2,
		CFG_COL_MAX = 2'd3
	} cfg_reg_t;

	// Segment in flight with the outcodes of both endpoints
	typedef struct packed {
		coord_t     ar;
		coord_t     ac;
		coord_t     br;
		coord_t     bc;
		logic [3:0] c0;
		logic [3:0] c1;
	} item_t;

	// Per-pass control carried alongside the divider
	typedef struct packed {
		logic active;
		logic row_edge;
		logic sel_b;
		logic neg;
		logic dzero;
	} ctl_t;

	// Bottom before top, right before left
	function automatic logic [3:0] outcode(coord_t r, coord_t c, coord_t rmin, coord_t rmax,
		coord_t cmin, coord_t cmax);
		logic [3:0] k;
		k = 4'h0;
		if (r > rmax) k = k | OC_BOTTOM;
		else if (r < rmin) k = k | OC_TOP;
		if (c > cmax) k = k | OC_RIGHT;
		else if (c < cmin) k = k | OC_LEFT;
		return k;
	endfunction

endpackage

/* hw/rtl/lsrc_pass.sv */
// One clip pass: edge select, multiply, bit-per-stage divide, add and new outcode.
// Depends on lsrc_pkg.
module lsrc_pass (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lsrc_pkg::item_t    in_item,
	input  lsrc_pkg::coord_t   row_min,
	input  lsrc_pkg::coord_t   row_max,
	input  lsrc_pkg::coord_t   col_min,
	input  lsrc_pkg::coord_t   col_max,
	output logic               out_valid,
	output lsrc_pkg::item_t    out_item
);
	import lsrc_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_MAX = (SUM_W'(1) << (COORD_WIDTH - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

	function automatic logic [MAG_W-1:0] mag(logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] a;
		a = v[DIFF_W-1] ? -v : v;
		return a[MAG_W-1:0];
	endfunction

	// setup stage
	logic                      valid_s1;
	item_t                     item_s1;
	ctl_t                      ctl_s1;
	coord_t                    base_s1;
	coord_t                    edge_s1;
	logic [MAG_W-1:0]          mnum_s1;
	logic [MAG_W-1:0]          me_s1;
	logic [MAG_W-1:0]          den_s1;

	ctl_t                      ctl_d;
	coord_t                    base_d;
	coord_t                    edge_d;
	logic signed [DIFF_W-1:0]  num_d;
	logic signed [DIFF_W-1:0]  e_d;
	logic signed [DIFF_W-1:0]  den_d;
	logic [3:0]                oc;

	// Pick the edge and form the interpolation operands
	always_comb begin
		oc             = (in_item.c0 != 4'h0) ? in_item.c0 : in_item.c1;
		ctl_d.active   = ((in_item.c0 | in_item.c1) != 4'h0) && ((in_item.c0 & in_item.c1) == 4'h0);
		ctl_d.sel_b    = (in_item.c0 == 4'h0);
		ctl_d.row_edge = ((oc & (OC_TOP | OC_BOTTOM)) != 4'h0);
		priority if ((oc & OC_TOP) != 4'h0) edge_d = row_min;
		else if ((oc & OC_BOTTOM) != 4'h0) edge_d = row_max;
		else if ((oc & OC_RIGHT) != 4'h0) edge_d = col_max;
		else edge_d = col_min;
		if (ctl_d.row_edge) begin
			base_d = in_item.ac;
			num_d  = DIFF_W'(in_item.bc) - DIFF_W'(in_item.ac);
			e_d    = DIFF_W'(edge_d) - DIFF_W'(in_item.ar);
			den_d  = DIFF_W'(in_item.br) - DIFF_W'(in_item.ar);
		end else begin
			base_d = in_item.ar;
			num_d  = DIFF_W'(in_item.br) - DIFF_W'(in_item.ar);
			e_d    = DIFF_W'(edge_d) - DIFF_W'(in_item.ac);
			den_d  = DIFF_W'(in_item.bc) - DIFF_W'(in_item.ac);
		end
		ctl_d.neg   = num_d[DIFF_W-1] ^ e_d[DIFF_W-1] ^ den_d[DIFF_W-1];
		ctl_d.dzero = (den_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		ctl_s1  <= ctl_d;
		base_s1 <= base_d;
		edge_s1 <= edge_d;
		mnum_s1 <= mag(num_d);
		me_s1   <= mag(e_d);
		den_s1  <= mag(den_d);
	end

	// divider stages; index 0 holds the product
	logic             dv_valid [PROD_W+1];
	item_t            dv_item  [PROD_W+1];
	ctl_t             dv_ctl   [PROD_W+1];
	coord_t           dv_base  [PROD_W+1];
	coord_t           dv_edge  [PROD_W+1];
	logic [MAG_W-1:0] dv_den   [PROD_W+1];
	logic [MAG_W-1:0] dv_rem   [PROD_W+1];
	logic [PROD_W-1:0] dv_pq   [PROD_W+1];

	// Multiply magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_valid[0] <= 1'b0;
		else dv_valid[0] <= valid_s1;
	end

	always_ff @(posedge clk) begin
		dv_item[0] <= item_s1;
		dv_ctl[0]  <= ctl_s1;
		dv_base[0] <= base_s1;
		dv_edge[0] <= edge_s1;
		dv_den[0]  <= den_s1;
		dv_rem[0]  <= '0;
		dv_pq[0]   <= PROD_W'(mnum_s1) * PROD_W'(me_s1);
	end

	// Restoring division, one quotient bit per stage
	for (genvar k = 0; k < PROD_W; k++) begin : g_div
		logic [MAG_W:0] t;
		logic           ge;

		always_comb begin
			t  = {dv_rem[k], dv_pq[k][PROD_W-1]};
			ge = (t >= {1'b0, dv_den[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_valid[k+1] <= 1'b0;
			else dv_valid[k+1] <= dv_valid[k];
		end

		always_ff @(posedge clk) begin
			dv_item[k+1] <= dv_item[k];
			dv_ctl[k+1]  <= dv_ctl[k];
			dv_base[k+1] <= dv_base[k];
			dv_edge[k+1] <= dv_edge[k];
			dv_den[k+1]  <= dv_den[k];
			dv_rem[k+1]  <= ge ? MAG_W'(t - {1'b0, dv_den[k]}) : t[MAG_W-1:0];
			dv_pq[k+1]   <= {dv_pq[k][PROD_W-2:0], ge};
		end
	end

	// Add the signed quotient to the base, saturate, move the endpoint
	logic                     valid_s3;
	item_t                    item_s3;
	logic                     active_s3;
	logic                     sel_b_s3;
	logic signed [SUM_W-1:0]  base_x;
	logic signed [SUM_W-1:0]  q_x;
	logic signed [SUM_W-1:0]  sum;
	coord_t                   val;
	coord_t                   nr;
	coord_t                   nc;
	item_t                    item_n;
	ctl_t                     ctl_f;

	always_comb begin
		ctl_f  = dv_ctl[PROD_W];
		base_x = SUM_W'(dv_base[PROD_W]);
		q_x    = signed'({2'b00, dv_pq[PROD_W]});
		sum    = ctl_f.neg ? base_x - q_x : base_x + q_x;
		priority if (ctl_f.dzero) val = dv_base[PROD_W];
		else if (sum > SUM_MAX) val = SUM_MAX[COORD_WIDTH-1:0];
		else if (sum < SUM_MIN) val = SUM_MIN[COORD_WIDTH-1:0];
		else val = sum[COORD_WIDTH-1:0];
		nr = ctl_f.row_edge ? dv_edge[PROD_W] : val;
		nc = ctl_f.row_edge ? val : dv_edge[PROD_W];
		item_n = dv_item[PROD_W];
		if (ctl_f.active) begin
			if (ctl_f.sel_b) begin
				item_n.br = nr;
				item_n.bc = nc;
			end else begin
				item_n.ar = nr;
				item_n.ac = nc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= dv_valid[PROD_W];
	end

	always_ff @(posedge clk) begin
		item_s3   <= item_n;
		active_s3 <= ctl_f.active;
		sel_b_s3  <= ctl_f.sel_b;
	end

	// Recode the moved endpoint
	item_t item_o;

	always_comb begin
		item_o = item_s3;
		if (active_s3) begin
			if (sel_b_s3)
				item_o.c1 = outcode(item_s3.br, item_s3.bc, row_min, row_max, col_min, col_max);
			else
				item_o.c0 = outcode(item_s3.ar, item_s3.ac, row_min, row_max, col_min, col_max);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= valid_s3;
	end

	always_ff @(posedge clk) begin
		out_item <= item_o;
	end

endmodule

/* hw/rtl/line_segment_rect_clip_core.sv */
// Cohen-Sutherland segment clipping core: window registers, clip passes, result stage.
// Depends on lsrc_pkg, lsrc_pass and line_segment_rect_clip_core_assert.svh.
//
//  channel  | signals                               | handshake
//  ---------+---------------------------------------+-------------------------
//  item in  | a_row a_col b_row b_col               | start while busy is low
//  result   | accepted out_a/b_row out_a/b_col      | done, one cycle, no hold
//  config   | cfg_idx cfg_wdata                     | cfg_we, taken at once
//
// An item enters every cycle; busy stays low. Each result passes the capture register,
// four clip passes of 52 stages each, of which 48 are the bit-per-stage divider, and
// the result register. Reset clears the valid bits and window registers.
// The result side cannot stall, so the pipeline never holds.
module line_segment_rect_clip_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [lsrc_pkg::COORD_WIDTH-1:0] a_row,
	input  logic signed [lsrc_pkg::COORD_WIDTH-1:0] a_col,
	input  logic signed [lsrc_pkg::COORD_WIDTH-1:0] b_row,
	input  logic signed [lsrc_pkg::COORD_WIDTH-1:0] b_col,
	output logic                                    done,
	output logic                                    accepted,
	output logic signed [lsrc_pkg::COORD_WIDTH-1:0] out_a_row,
	output logic signed [lsrc_pkg::COORD_WIDTH-1:0] out_a_col,
	output logic signed [lsrc_pkg::COORD_WIDTH-1:0] out_b_row,
	output logic signed [lsrc_pkg::COORD_WIDTH-1:0] out_b_col,
	input  logic                                    cfg_we,
	input  logic [lsrc_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  logic signed [lsrc_pkg::COORD_WIDTH-1:0] cfg_wdata
);
	import lsrc_pkg::*;

	`include "line_segment_rect_clip_core_assert.svh"

	coord_t row_min_q;
	coord_t row_max_q;
	coord_t col_min_q;
	coord_t col_max_q;

	// Write window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_min_q <= '0;
			row_max_q <= '0;
			col_min_q <= '0;
			col_max_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_ROW_MIN: row_min_q <= cfg_wdata;
				CFG_ROW_MAX: row_max_q <= cfg_wdata;
				CFG_COL_MIN: col_min_q <= cfg_wdata;
				CFG_COL_MAX: col_max_q <= cfg_wdata;
			endcase
		end
	end

	assign busy = 1'b0;

	// Capture the item with its initial outcodes
	logic  valid_s0;
	item_t item_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s0 <= 1'b0;
		else valid_s0 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		item_s0.ar <= a_row;
		item_s0.ac <= a_col;
		item_s0.br <= b_row;
		item_s0.bc <= b_col;
		item_s0.c0 <= outcode(a_row, a_col, row_min_q, row_max_q, col_min_q, col_max_q);
		item_s0.c1 <= outcode(b_row, b_col, row_min_q, row_max_q, col_min_q, col_max_q);
	end

	// Chain the clip passes
	logic  pass_valid [MAX_CLIP_STEPS];
	item_t pass_item  [MAX_CLIP_STEPS];

	for (genvar p = 0; p < MAX_CLIP_STEPS; p++) begin : g_pass
		logic  vin;
		item_t iin;

		if (p == 0) begin : g_first
			assign vin = valid_s0;
			assign iin = item_s0;
		end else begin : g_next
			assign vin = pass_valid[p-1];
			assign iin = pass_item[p-1];
		end

		lsrc_pass u_pass (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vin),
			.in_item  (iin),
			.row_min  (row_min_q),
			.row_max  (row_max_q),
			.col_min  (col_min_q),
			.col_max  (col_max_q),
			.out_valid(pass_valid[p]),
			.out_item (pass_item[p])
		);
	end

	// Drive the result: endpoints only when both codes are clear
	item_t fin;
	logic  acc;

	always_comb begin
		fin = pass_item[MAX_CLIP_STEPS-1];
		acc = ((fin.c0 | fin.c1) == 4'h0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= pass_valid[MAX_CLIP_STEPS-1];
	end

	always_ff @(posedge clk) begin
		accepted  <= acc;
		out_a_row <= acc ? fin.ar : '0;
		out_a_col <= acc ? fin.ac : '0;
		out_b_row <= acc ? fin.br : '0;
		out_b_col <= acc ? fin.bc : '0;
	end

	`LSRC_ASSERT_IMP(a_reject_zero, clk, arst_n, done && !accepted, out_a_row == '0 && out_a_col == '0 && out_b_row == '0 && out_b_col == '0, "rejected item carries endpoints")
	`LSRC_ASSERT_IMP(a_accept_in_window, clk, arst_n, done && accepted, out_a_row >= row_min_q && out_a_row <= row_max_q && out_b_row >= row_min_q && out_b_row <= row_max_q && out_a_col >= col_min_q && out_a_col <= col_max_q && out_b_col >= col_min_q && out_b_col <= col_max_q, "accepted endpoint outside window")
	`LSRC_ASSERT_NXT(a_last_pass_done, clk, arst_n, pass_valid[MAX_CLIP_STEPS-1], done, "finished item not delivered")

endmodule

/* dv/tb.sv */
// Self-checking bench for the segment clipping core: directed and random segments
// against several window settings, predicted by a scoreboard class. Depends on lsrc_pkg.
module tb;
	import lsrc_pkg::*;

	localparam longint CMAXV    = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
	localparam longint CMINV    = -CMAXV - 1;
	localparam int     WD_LIMIT = 5000;

	typedef struct {
		logic   acc;
		coord_t ar, ac, br, bc;
	} clip_res_t;

	// Window copy, clip predictor and queue of expected clip results
	class clip_scoreboard;
		coord_t    win[4];
		clip_res_t pending[$];
		int        errors;

		function new();
			foreach (win[i]) win[i] = '0;
			errors = 0;
		endfunction

		function void set_window(cfg_reg_t idx, coord_t v);
			win[idx] = v;
		endfunction

		// Bottom before top, right before left
		function logic [3:0] region(longint r, longint c);
			logic [3:0] k;
			k = 4'h0;
			if (r > longint'(win[CFG_ROW_MAX])) k |= OC_BOTTOM;
			else if (r < longint'(win[CFG_ROW_MIN])) k |= OC_TOP;
			if (c > longint'(win[CFG_COL_MAX])) k |= OC_RIGHT;
			else if (c < longint'(win[CFG_COL_MIN])) k |= OC_LEFT;
			return k;
		endfunction

		// base + num * e / den, truncated toward zero, then saturated
		function longint edge_cross(longint base, longint num, longint e, longint den);
			longint res;
			if (den == 0) return base;
			res = base + (num * e) / den;
			if (res > CMAXV) res = CMAXV;
			if (res < CMINV) res = CMINV;
			return res;
		endfunction

		function void note_segment(coord_t a_r, coord_t a_c, coord_t b_r, coord_t b_c);
			longint    ar, ac, br, bc, nr, nc;
			logic [3:0] c0, c1, oc;
			clip_res_t  res;
			ar = a_r; ac = a_c; br = b_r; bc = b_c;
			c0 = region(ar, ac);
			c1 = region(br, bc);
			for (int p = 0; p < MAX_CLIP_STEPS; p++) begin
				if ((c0 | c1) == 0 || (c0 & c1) != 0) break;
				oc = (c0 != 0) ? c0 : c1;
				if (oc & OC_TOP) begin
					nr = win[CFG_ROW_MIN];
					nc = edge_cross(ac, bc - ac, nr - ar, br - ar);
				end else if (oc & OC_BOTTOM) begin
					nr = win[CFG_ROW_MAX];
					nc = edge_cross(ac, bc - ac, nr - ar, br - ar);
				end else if (oc & OC_RIGHT) begin
					nc = win[CFG_COL_MAX];
					nr = edge_cross(ar, br - ar, nc - ac, bc - ac);
				end else begin
					nc = win[CFG_COL_MIN];
					nr = edge_cross(ar, br - ar, nc - ac, bc - ac);
				end
				if (c0 != 0) begin
					ar = nr; ac = nc; c0 = region(ar, ac);
				end else begin
					br = nr; bc = nc; c1 = region(br, bc);
				end
			end
			res.acc = ((c0 | c1) == 0);
			res.ar  = res.acc ? coord_t'(ar) : '0;
			res.ac  = res.acc ? coord_t'(ac) : '0;
			res.br  = res.acc ? coord_t'(br) : '0;
			res.bc  = res.acc ? coord_t'(bc) : '0;
			pending.push_back(res);
		endfunction

		function void check_result(logic acc, coord_t ar, coord_t ac, coord_t br, coord_t bc);
			clip_res_t ex;
			if (pending.size() == 0) begin
				$display("%0t: clip result with none expected", $time);
				errors++;
				return;
			end
			ex = pending.pop_front();
			if (acc !== ex.acc) begin
				$display("%0t: accepted exp %0d got %0d", $time, ex.acc, acc);
				errors++;
			end
			if (ar !== ex.ar) begin
				$display("%0t: out_a_row exp %0d got %0d", $time, ex.ar, ar);
				errors++;
			end
			if (ac !== ex.ac) begin
				$display("%0t: out_a_col exp %0d got %0d", $time, ex.ac, ac);
				errors++;
			end
			if (br !== ex.br) begin
				$display("%0t: out_b_row exp %0d got %0d", $time, ex.br, br);
				errors++;
			end
			if (bc !== ex.bc) begin
				$display("%0t: out_b_col exp %0d got %0d", $time, ex.bc, bc);
				errors++;
			end
		endfunction
	endclass

	logic                 clk, arst_n, start, busy, done, accepted;
	coord_t               a_row, a_col, b_row, b_col;
	coord_t               out_a_row, out_a_col, out_b_row, out_b_col;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	coord_t               cfg_wdata;

	clip_scoreboard sb;
	int             quiet_cycles;
	bit             no_idle;

	line_segment_rect_clip_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_row(a_row), .a_col(a_col), .b_row(b_row), .b_col(b_col),
		.done(done), .accepted(accepted),
		.out_a_row(out_a_row), .out_a_col(out_a_col),
		.out_b_row(out_b_row), .out_b_col(out_b_col),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each result as it leaves
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(accepted, out_a_row, out_a_col, out_b_row, out_b_col);
	end

	// Watchdog: count cycles in which no item and no result moves
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("FAIL line_segment_rect_clip_core");
				$finish;
			end
		end
	end

	// Write one window register; called at a falling edge
	task automatic write_reg(cfg_reg_t idx, coord_t v);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = v;
		sb.set_window(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_window(coord_t rmin, coord_t rmax, coord_t cmin, coord_t cmax);
		write_reg(CFG_ROW_MIN, rmin);
		write_reg(CFG_ROW_MAX, rmax);
		write_reg(CFG_COL_MIN, cmin);
		write_reg(CFG_COL_MAX, cmax);
	endtask

	// Offer one segment and hold it until taken; leaves at a falling edge
	task automatic send_segment(coord_t ar, coord_t ac, coord_t br, coord_t bc);
		a_row = ar; a_col = ac; b_row = br; b_col = bc;
		start = 1'b1;
		do @(posedge clk); while (busy);
		sb.note_segment(ar, ac, br, bc);
		@(negedge clk);
	endtask

	// Drop start for a random gap, about 13 in a hundred items
	task automatic maybe_idle();
		if (!no_idle && $urandom_range(0, 99) < 13) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// Hold off until every expected clip result has come back
	task automatic drain();
		start = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Coordinate near one window span, or anywhere in range
	function automatic coord_t pick(coord_t lo, coord_t hi);
		longint l, h, v;
		if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
		l = (lo < hi) ? lo : hi;
		h = (lo < hi) ? hi : lo;
		if (h - l > 64'sd1_000_000_000) return coord_t'($urandom);
		v = l - 2048 + longint'($urandom_range(0, int'(h - l) + 4096));
		if (v > CMAXV) v = CMAXV;
		if (v < CMINV) v = CMINV;
		return coord_t'(v);
	endfunction

	task automatic random_phase(int n);
		coord_t rmin, rmax, cmin, cmax;
		rmin = sb.win[CFG_ROW_MIN]; rmax = sb.win[CFG_ROW_MAX];
		cmin = sb.win[CFG_COL_MIN]; cmax = sb.win[CFG_COL_MAX];
		for (int i = 0; i < n; i++) begin
			maybe_idle();
			send_segment(pick(rmin, rmax), pick(cmin, cmax), pick(rmin, rmax),
				pick(cmin, cmax));
		end
		drain();
	endtask

	localparam coord_t CMAX24 = coord_t'(CMAXV);
	localparam coord_t CMIN24 = coord_t'(CMINV);

	initial begin
		sb        = new();
		no_idle   = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		a_row     = '0; a_col = '0; b_row = '0; b_col = '0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset window is the single point at the origin
		send_segment(24'sd0, 24'sd0, 24'sd0, 24'sd0);
		send_segment(-24'sd256, 24'sd0, 24'sd256, 24'sd0);
		send_segment(CMIN24, CMIN24, CMAX24, CMAX24);
		drain();

		// Directed segments against a moderate window
		set_window(-24'sd1000, 24'sd2000, -24'sd3000, 24'sd4000);
		send_segment(24'sd0, 24'sd0, 24'sd100, 24'sd100);          // wholly inside
		send_segment(-24'sd1000, -24'sd3000, 24'sd2000, 24'sd4000); // on the corners
		send_segment(-24'sd5000, 24'sd0, -24'sd6000, 24'sd10);     // both above
		send_segment(24'sd0, 24'sd9000, 24'sd10, 24'sd8000);       // both right
		send_segment(-24'sd5000, 24'sd0, 24'sd0, 24'sd0);          // crosses top
		send_segment(24'sd0, 24'sd77, 24'sd9000, 24'sd333);        // crosses bottom
		send_segment(24'sd5, 24'sd0, 24'sd17, 24'sd9999);          // crosses right
		send_segment(24'sd5, -24'sd9999, 24'sd17, 24'sd0);         // crosses left
		send_segment(-24'sd9000, -24'sd9000, 24'sd9000, 24'sd9000); // through both ends
		send_segment(-24'sd9000, 24'sd3000, 24'sd3000, 24'sd9000);  // misses a corner
		send_segment(-24'sd1700, -24'sd4100, 24'sd2600, 24'sd5200); // many passes
		send_segment(CMIN24, CMIN24, CMAX24, CMAX24);
		send_segment(CMAX24, CMIN24, CMIN24, CMAX24);
		send_segment(CMIN24, 24'sd0, CMAX24, 24'sd1);
		send_segment(24'sd0, CMAX24, 24'sd0, CMIN24);
		drain();

		// Inverted window: every point lies outside
		set_window(24'sd500, -24'sd500, 24'sd500, -24'sd500);
		send_segment(24'sd0, 24'sd0, 24'sd10, 24'sd10);
		send_segment(-24'sd900, -24'sd900, 24'sd900, 24'sd900);
		random_phase(60);

		// Random phases over several windows, extremes among them
		set_window(-24'sd1000, 24'sd2000, -24'sd3000, 24'sd4000);
		random_phase(150);
		no_idle = 1'b1;
		set_window(24'sd256, 24'sd20000, -24'sd700, 24'sd300);
		random_phase(120);
		no_idle = 1'b0;
		set_window(CMIN24, CMAX24, CMIN24, CMAX24);
		random_phase(90);
		set_window(CMAX24, CMAX24, CMIN24, CMIN24);
		random_phase(60);
		set_window(-24'sd2000000, 24'sd3000000, -24'sd50, 24'sd50);
		random_phase(120);
		set_window(24'sd0, 24'sd0, 24'sd0, 24'sd0);
		random_phase(60);

		repeat (250) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS line_segment_rect_clip_core");
		end else begin
			$display("FAIL line_segment_rect_clip_core");
		end
		$finish;
	end
endmodule
